// File: rtl/cbt_pkg.sv
// ----------------------------------------------------------------------------
// cbt_pkg
// shared types, constants and the basis weight function of the cubic
// b-spline tessellator
// ----------------------------------------------------------------------------
package cbt_pkg;

    localparam int COORD_W          = 32;   // q16.16 coordinate width
    localparam int NUM_TAPS         = 4;    // control points per span
    localparam int SPAN_SAMPLES_DEF = 16;   // default samples per span
    localparam int Q_DEPTH          = 2;    // task queue depth
    localparam int LANE_LAT         = 5;    // mult, two adds, two reciprocal stages

    // one unit of work for the back end
    typedef struct packed {
        logic [NUM_TAPS-1:0][COORD_W-1:0] px;     // oldest point at index 0
        logic [NUM_TAPS-1:0][COORD_W-1:0] py;
        logic                             pass;   // curve too short, points pass through
        logic                             fin;    // closed by the curve's final point
        logic [1:0]                       first;  // first tap sent out when passing through
    } t_task;

    // per-sample control that travels beside the datapath
    typedef struct packed {
        logic valid;
        logic run_end;
        logic curve_end;
    } t_ctrl;

    // basis weight of one tap at sample s of n, scaled by 6*n^3
    function automatic int bspline_weight(input int tap, input int s, input int n);
        int u;
        int w;
        u = n - s;
        unique case (tap)
            0:       w = u * u * u;
            1:       w = 3 * s * s * s - 6 * s * s * n + 4 * n * n * n;
            2:       w = -3 * s * s * s + 3 * s * s * n + 3 * s * n * n + n * n * n;
            3:       w = s * s * s;
            default: w = 0;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/cubic_bspline_tessellator.sv
// ----------------------------------------------------------------------------
// cubic_bspline_tessellator
// uniform cubic b-spline evaluation: control points in, curve samples out
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata (lowest bit up)          tlast        tuser
//  -------  ---  -----------------------------  -----------  ---------
//  s        in   point_x[31:0], point_y[63:32]  final_point  -
//  m        out  sample_x[31:0], sample_y[63:32] run_end     curve_end
//
//  a point that closes a span gives SAMPLES_PER_SPAN words, one a cycle
//  unless stalled, or SAMPLES_PER_SPAN+1 on the final point of a curve; a
//  short curve gives its stored points and the final point, up to three words
//  the back-end sequencer issues one sample per cycle while the output does
//  not stall and sets the rate; with the back end idle the first word of a
//  taken point passes the task queue, the sequencer and the lane pipeline
//  synchronous active-low reset clears the point window and count, queue and
//  all valids
//  an output stall freezes the sample pipeline; the two-entry task queue
//  lets the front keep taking points until it fills
//
module cubic_bspline_tessellator #(
    parameter int SAMPLES_PER_SPAN = cbt_pkg::SPAN_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // control point stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [2*cbt_pkg::COORD_W-1:0] i_s_tdata,   // point_x, point_y
    input  logic                          i_s_tlast,   // final_point
    // sample stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [2*cbt_pkg::COORD_W-1:0] o_m_tdata,   // sample_x, sample_y
    output logic                          o_m_tlast,   // run_end
    output logic [0:0]                    o_m_tuser    // curve_end
);

    localparam int CW  = cbt_pkg::COORD_W;
    localparam int WW  = $clog2(6 * SAMPLES_PER_SPAN ** 3 + 1);
    localparam int LAT = cbt_pkg::LANE_LAT;

    // front to queue
    logic           push;
    logic           q_ready;
    cbt_pkg::t_task f_task;
    // queue to back end
    logic           q_valid;
    logic           q_pop;
    cbt_pkg::t_task q_task;
    // issued sample
    cbt_pkg::t_ctrl                      s_ctrl;
    logic [cbt_pkg::NUM_TAPS-1:0][CW-1:0] s_px;
    logic [cbt_pkg::NUM_TAPS-1:0][CW-1:0] s_py;
    logic [cbt_pkg::NUM_TAPS-1:0][WW-1:0] s_w;
    // sample pipeline
    cbt_pkg::t_ctrl r_ctrl [LAT];
    logic [CW-1:0]  x_coord;
    logic [CW-1:0]  y_coord;
    logic           adv;
    logic           s_accept;

    // whole back pipeline moves when the output word is free or taken
    assign adv      = !o_m_tvalid || i_m_tready;
    assign s_accept = i_s_tvalid && o_s_tready;

    cbt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_x       (i_s_tdata[CW-1:0]),
        .i_y       (i_s_tdata[2*CW-1:CW]),
        .i_fin     (i_s_tlast),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_task    (f_task)
    );

    cbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_task),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_task),
        .i_pop   (q_pop)
    );

    cbt_seq #(
        .SAMPLES_PER_SPAN (SAMPLES_PER_SPAN)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_q_valid (q_valid),
        .i_q_task  (q_task),
        .o_q_pop   (q_pop),
        .o_ctrl    (s_ctrl),
        .o_px      (s_px),
        .o_py      (s_py),
        .o_weights (s_w)
    );

    cbt_lane #(
        .SAMPLES_PER_SPAN (SAMPLES_PER_SPAN)
    ) u_lane_x (
        .i_clk     (i_clk),
        .i_en      (adv),
        .i_points  (s_px),
        .i_weights (s_w),
        .o_coord   (x_coord)
    );

    cbt_lane #(
        .SAMPLES_PER_SPAN (SAMPLES_PER_SPAN)
    ) u_lane_y (
        .i_clk     (i_clk),
        .i_en      (adv),
        .i_points  (s_py),
        .i_weights (s_w),
        .o_coord   (y_coord)
    );

    // control flags ride beside the two lanes with matching latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_ctrl[k] <= '0;
            end
        end else if (adv) begin
            r_ctrl[0] <= s_ctrl;
            for (int k = 1; k < LAT; k++) begin
                r_ctrl[k] <= r_ctrl[k-1];
            end
        end
    end

    assign o_m_tvalid   = r_ctrl[LAT-1].valid;
    assign o_m_tlast    = r_ctrl[LAT-1].run_end;
    assign o_m_tuser[0] = r_ctrl[LAT-1].curve_end;
    assign o_m_tdata    = {y_coord, x_coord};

`ifndef ASSERT_OFF
    // a final point always produces output, so it must become a task
    a_final_makes_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tlast) |-> push)
        else $error("final point accepted without a task");

    // the last word of a curve also closes its run
    a_curve_end_is_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> o_m_tlast)
        else $error("curve_end without run_end");

    // reset empties the sample pipeline
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

// File: rtl/cbt_front.sv
// ----------------------------------------------------------------------------
// cbt_front
// takes control points, keeps the last three and a point count, and turns
// every point that produces samples into a task for the back end
// ----------------------------------------------------------------------------
module cbt_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [cbt_pkg::COORD_W-1:0] i_x,
    input  logic [cbt_pkg::COORD_W-1:0] i_y,
    input  logic                        i_fin,
    input  logic                        i_q_ready,
    output logic                        o_push,
    output cbt_pkg::t_task              o_task
);

    logic [cbt_pkg::COORD_W-1:0] r_win_x [3];
    logic [cbt_pkg::COORD_W-1:0] r_win_y [3];
    logic [1:0]                  r_seen;
    logic                        n_accept;

    assign o_ready  = i_q_ready;
    assign n_accept = i_valid && i_q_ready;
    assign o_push   = n_accept && (r_seen == 2'd3 || i_fin);

    always_comb begin
        o_task.px    = {i_x, r_win_x[2], r_win_x[1], r_win_x[0]};
        o_task.py    = {i_y, r_win_y[2], r_win_y[1], r_win_y[0]};
        o_task.pass  = (r_seen != 2'd3);
        o_task.fin   = i_fin;
        o_task.first = 2'd3 - r_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 2'd0;
            for (int k = 0; k < 3; k++) begin
                r_win_x[k] <= '0;
                r_win_y[k] <= '0;
            end
        end else if (n_accept) begin
            r_win_x[0] <= r_win_x[1];
            r_win_x[1] <= r_win_x[2];
            r_win_x[2] <= i_x;
            r_win_y[0] <= r_win_y[1];
            r_win_y[1] <= r_win_y[2];
            r_win_y[2] <= i_y;
            if (i_fin) begin
                r_seen <= 2'd0;
            end else if (r_seen != 2'd3) begin
                r_seen <= r_seen + 2'd1;
            end
        end
    end

endmodule

// File: rtl/cbt_queue.sv
// ----------------------------------------------------------------------------
// cbt_queue
// small task fifo between front end and back end
// ----------------------------------------------------------------------------
module cbt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cbt_pkg::t_task i_data,
    output logic           o_ready,
    output logic           o_valid,
    output cbt_pkg::t_task o_data,
    input  logic           i_pop
);

    localparam int PW = (cbt_pkg::Q_DEPTH > 1) ? $clog2(cbt_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(cbt_pkg::Q_DEPTH + 1);

    cbt_pkg::t_task r_mem [cbt_pkg::Q_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic           n_push;
    logic           n_pop;

    assign o_ready = (r_count != CW'(cbt_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign n_push  = i_push && o_ready;
    assign n_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (n_push) begin
                r_wr <= (r_wr == PW'(cbt_pkg::Q_DEPTH - 1)) ? '0 : PW'(r_wr + 1'b1);
            end
            if (n_pop) begin
                r_rd <= (r_rd == PW'(cbt_pkg::Q_DEPTH - 1)) ? '0 : PW'(r_rd + 1'b1);
            end
            if (n_push && !n_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (n_pop && !n_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

endmodule

// File: rtl/cbt_seq.sv
// ----------------------------------------------------------------------------
// cbt_seq
// back-end sequencer: walks the samples of one task and, unless stalled,
// issues the points, basis weights and end flags of one sample per cycle
// ----------------------------------------------------------------------------
module cbt_seq #(
    parameter int SAMPLES_PER_SPAN = cbt_pkg::SPAN_SAMPLES_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_adv,
    input  logic                                              i_q_valid,
    input  cbt_pkg::t_task                                    i_q_task,
    output logic                                              o_q_pop,
    output cbt_pkg::t_ctrl                                    o_ctrl,
    output logic [cbt_pkg::NUM_TAPS-1:0][cbt_pkg::COORD_W-1:0] o_px,
    output logic [cbt_pkg::NUM_TAPS-1:0][cbt_pkg::COORD_W-1:0] o_py,
    output logic [cbt_pkg::NUM_TAPS-1:0][$clog2(6*SAMPLES_PER_SPAN**3+1)-1:0] o_weights
);

    localparam int DEN = 6 * SAMPLES_PER_SPAN ** 3;
    localparam int WW  = $clog2(DEN + 1);
    localparam int JW  = $clog2(SAMPLES_PER_SPAN + 1);

    logic [cbt_pkg::NUM_TAPS-1:0][WW-1:0] w_tab [SAMPLES_PER_SPAN+1];
    logic [cbt_pkg::NUM_TAPS-1:0][WW-1:0] n_w;
    logic [cbt_pkg::NUM_TAPS-1:0][WW-1:0] r_w;
    logic [cbt_pkg::NUM_TAPS-1:0][cbt_pkg::COORD_W-1:0] r_px;
    logic [cbt_pkg::NUM_TAPS-1:0][cbt_pkg::COORD_W-1:0] r_py;
    cbt_pkg::t_task r_task;
    cbt_pkg::t_ctrl r_ctrl;
    logic           r_busy;
    logic [JW-1:0]  r_j;
    logic           n_last;
    logic           n_take;

    // weight table, one row per sample position
    for (genvar g = 0; g <= SAMPLES_PER_SPAN; g++) begin : g_row
        for (genvar t = 0; t < cbt_pkg::NUM_TAPS; t++) begin : g_tap
            assign w_tab[g][t] = WW'(cbt_pkg::bspline_weight(t, g, SAMPLES_PER_SPAN));
        end
    end

    always_comb begin
        if (r_task.pass) begin
            n_last = (r_j == JW'(3));
        end else begin
            n_last = (r_j == (r_task.fin ? JW'(SAMPLES_PER_SPAN) : JW'(SAMPLES_PER_SPAN - 1)));
        end
        n_take = i_adv && (!r_busy || n_last);
        for (int i = 0; i < cbt_pkg::NUM_TAPS; i++) begin
            if (r_task.pass) begin
                // full weight on one tap gives the point back unchanged
                n_w[i] = (r_j[1:0] == 2'(i)) ? WW'(DEN) : '0;
            end else begin
                n_w[i] = w_tab[r_j][i];
            end
        end
    end

    assign o_q_pop   = n_take && i_q_valid;
    assign o_ctrl    = r_ctrl;
    assign o_px      = r_px;
    assign o_py      = r_py;
    assign o_weights = r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ctrl <= '0;
        end else if (i_adv) begin
            r_ctrl.valid     <= r_busy;
            r_ctrl.run_end   <= n_last;
            r_ctrl.curve_end <= n_last && r_task.fin;
            r_w              <= n_w;
            r_px             <= r_task.px;
            r_py             <= r_task.py;
            if (n_take) begin
                r_busy <= i_q_valid;
                r_task <= i_q_task;
                r_j    <= i_q_task.pass ? JW'(i_q_task.first) : '0;
            end else begin
                r_j <= JW'(r_j + 1'b1);
            end
        end
    end

endmodule

// File: rtl/cbt_lane.sv
// ----------------------------------------------------------------------------
// cbt_lane
// one coordinate: weighted sum of four points, then a divide by 6*n^3 with
// round half up, done as a shift and a reciprocal multiply
// ----------------------------------------------------------------------------
module cbt_lane #(
    parameter int SAMPLES_PER_SPAN = cbt_pkg::SPAN_SAMPLES_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_en,
    input  logic [cbt_pkg::NUM_TAPS-1:0][cbt_pkg::COORD_W-1:0] i_points,
    input  logic [cbt_pkg::NUM_TAPS-1:0][$clog2(6*SAMPLES_PER_SPAN**3+1)-1:0] i_weights,
    output logic [cbt_pkg::COORD_W-1:0]                        o_coord
);

    // number of low zero bits of a positive constant
    function automatic int trailing_zeros(input int v);
        int c;
        c = 0;
        while (c < 31 && v[c] == 1'b0) begin
            c++;
        end
        return c;
    endfunction

    localparam int CW   = cbt_pkg::COORD_W;
    localparam int DEN  = 6 * SAMPLES_PER_SPAN ** 3;
    localparam int DW   = $clog2(DEN + 1);
    localparam int PW   = CW + DW + 1;          // signed product width
    localparam int SW   = CW + DW + 2;          // signed sum width
    // half for rounding, plus 2^31 quotients so the dividend is never negative
    localparam logic [SW-1:0] BIAS = SW'(DEN / 2) + (SW'(DEN) << (CW - 1));
    // divisor is 2^TZ times an odd part, the odd part goes by reciprocal
    localparam int TZ   = trailing_zeros(DEN);
    localparam int DO   = DEN >> TZ;
    localparam int LD   = $clog2(DO);
    localparam int TW   = CW + LD;              // shifted dividend width
    localparam int K    = CW + 2 * LD;          // reciprocal scale, exact for every dividend
    localparam int MW   = CW + LD + 1;          // reciprocal width
    localparam int HW   = (MW + 1) / 2;         // low part of the split multiply
    localparam int FW   = TW + MW;              // full product width
    localparam logic [MW-1:0]    RECIP    = MW'(((128'd1 << K) + 128'(DO - 1)) / 128'(DO));
    localparam logic [MW-HW-1:0] RECIP_HI = RECIP[MW-1:HW];
    localparam logic [HW-1:0]    RECIP_LO = RECIP[HW-1:0];

    logic signed [PW-1:0]    r_prod [cbt_pkg::NUM_TAPS];
    logic signed [SW-1:0]    r_pair [2];
    logic        [SW-1:0]    r_sum;
    logic        [TW-1:0]    n_t;
    logic        [TW+MW-HW-1:0] r_hi;
    logic        [TW+HW-1:0] r_lo;
    logic        [FW-1:0]    n_full;
    logic        [CW-1:0]    r_q;

    assign n_t    = r_sum[TZ +: TW];
    assign n_full = (FW'(r_hi) << HW) + FW'(r_lo);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < cbt_pkg::NUM_TAPS; i++) begin
                r_prod[i] <= PW'($signed(i_points[i]) * $signed({1'b0, i_weights[i]}));
            end
            r_pair[0] <= SW'(r_prod[0]) + SW'(r_prod[1]);
            r_pair[1] <= SW'(r_prod[2]) + SW'(r_prod[3]);
            r_sum     <= SW'(r_pair[0] + r_pair[1]) + BIAS;
            // quotient by the odd part, reciprocal split in two halves
            r_hi      <= (TW+MW-HW)'(n_t) * (TW+MW-HW)'(RECIP_HI);
            r_lo      <= (TW+HW)'(n_t) * (TW+HW)'(RECIP_LO);
            r_q       <= n_full[K +: CW];
        end
    end

    // remove the 2^31 offset
    assign o_coord = {~r_q[CW-1], r_q[CW-2:0]};

endmodule
